FILE: rtl/dstq_pkg.sv
// Package for the deadline-sorted timer queue.
// Holds sizes, operation codes and the front-to-back command type; no dependencies.
package dstq_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_BITS = 4;
  localparam int TIME_BITS = 64;
  localparam int IVL_BITS  = 32;
  localparam int FIFO_DEPTH = 2;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [SLOT_BITS-1:0] slot;
    logic [IVL_BITS-1:0]  ivl;
    logic                 rep;
  } cmd_t;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
endpackage

FILE: rtl/dstq_front.sv
// Front end: accepts requests, drops meaningless ones, queues the rest.
// Depends on dstq_pkg.
module dstq_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 mode_i,
  input  logic [dstq_pkg::SLOT_BITS-1:0] slot_i,
  input  logic [31:0]                interval_i,
  input  logic                       repeat_req_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output dstq_pkg::cmd_t             cmd_o
);
  import dstq_pkg::*;

  cmd_t       mem_q [FIFO_DEPTH];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       keep, push, pop;

  // Mode 3 does nothing, so it is accepted and dropped here.
  assign keep = mode_i inside {OP_TICK, OP_START, OP_STOP};
  assign in_ready_o  = (cnt_q != 2'(FIFO_DEPTH));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{op: mode_i, slot: slot_i, ivl: interval_i, rep: repeat_req_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(FIFO_DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");
endmodule

FILE: rtl/dstq_back.sv
// Back end: slot table, time counter and the expiry scanner.
// Depends on dstq_pkg; fed by dstq_front.
module dstq_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  dstq_pkg::cmd_t                 cmd_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dstq_pkg::SLOT_BITS-1:0] fired_slot_o,
  output logic [63:0]                    fire_time_o,
  output logic                           last_o
);
  import dstq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIRE = 2'd2;

  logic [1:0]           state_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] dl_q [NUM_SLOTS];
  logic [IVL_BITS-1:0]  iv_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] per_q, arm_q, done_q;
  logic [SLOT_BITS-1:0] ord_q [NUM_SLOTS];

  // Scanner: one slot per cycle.
  logic [SLOT_BITS-1:0] idx_q, best_q;
  logic                 found_q;

  // Pending result: the best of the last pass, ready to report.
  logic [SLOT_BITS-1:0] fslot_q;
  logic                 fvalid_q;

  // Output register.
  logic                 ov_q, olast_q;
  logic [SLOT_BITS-1:0] oslot_q;
  logic [TIME_BITS-1:0] otime_q;

  logic                 cand, better, ofree, mk_new;
  logic [SLOT_BITS-1:0] mk_slot;
  logic [TIME_BITS-1:0] mk_dl;
  logic [TIME_BITS:0]   sum;
  logic [IVL_BITS-1:0]  addv;
  logic                 is_start, is_stop, take_cmd;

  assign ofree = !ov_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign take_cmd = cmd_valid_i && cmd_ready_o;
  assign is_start = take_cmd && (cmd_i.op == OP_START);
  assign is_stop  = take_cmd && (cmd_i.op == OP_STOP);

  assign cand = arm_q[idx_q] && !done_q[idx_q] && (dl_q[idx_q] <= now_q);
  assign better = !found_q || (dl_q[idx_q] < dl_q[best_q]) ||
                  ((dl_q[idx_q] == dl_q[best_q]) && (ord_q[idx_q] < ord_q[best_q]));

  // Re-arm deadline, shared by start and periodic re-arm.
  always_comb begin
    if (is_start) begin
      addv = cmd_i.ivl;
      mk_slot = cmd_i.slot;
    end else begin
      addv = (iv_q[fslot_q] == '0) ? IVL_BITS'(1) : iv_q[fslot_q];
      mk_slot = fslot_q;
    end
    sum = {1'b0, now_q} + (TIME_BITS+1)'(addv);
    mk_dl = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  end

  logic fire_now;
  assign fire_now = (state_q == ST_FIRE) && ofree;
  assign mk_new = is_start || (fire_now && per_q[fslot_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      now_q <= '0;
      per_q <= '0; arm_q <= '0; done_q <= '0;
      idx_q <= '0; best_q <= '0; found_q <= 1'b0;
      fslot_q <= '0; fvalid_q <= 1'b0;
      ov_q <= 1'b0; olast_q <= 1'b0; oslot_q <= '0; otime_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        dl_q[i] <= TIME_MAX;
        iv_q[i] <= '0;
        ord_q[i] <= SLOT_BITS'(i);
      end
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (mk_new) begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (ord_q[i] > ord_q[mk_slot]) ord_q[i] <= ord_q[i] - 1'b1;
        ord_q[mk_slot] <= SLOT_BITS'(NUM_SLOTS - 1);
        dl_q[mk_slot] <= mk_dl;
      end
      case (state_q)
        ST_IDLE: begin
          if (is_start) begin
            iv_q[cmd_i.slot] <= cmd_i.ivl;
            per_q[cmd_i.slot] <= cmd_i.rep;
            arm_q[cmd_i.slot] <= 1'b1;
          end else if (is_stop) begin
            arm_q[cmd_i.slot] <= 1'b0;
            dl_q[cmd_i.slot] <= TIME_MAX;
          end else if (take_cmd) begin
            now_q <= now_q + 1'b1;
            done_q <= '0;
            idx_q <= '0; found_q <= 1'b0; fvalid_q <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cand && better) begin
            best_q <= idx_q; found_q <= 1'b1;
          end
          if (idx_q == SLOT_BITS'(NUM_SLOTS - 1)) begin
            // Pass end: report a held result, knowing if another follows; else hold this best and rescan, or idle.
            if (fvalid_q) state_q <= ST_FIRE;
            else if (found_q || cand) begin
              fslot_q <= (cand && better) ? idx_q : best_q;
              fvalid_q <= 1'b1;
              done_q[(cand && better) ? idx_q : best_q] <= 1'b1;
              idx_q <= '0; found_q <= 1'b0;
            end else state_q <= ST_IDLE;
          end else idx_q <= idx_q + 1'b1;
        end
        ST_FIRE: begin
          if (ofree) begin
            ov_q <= 1'b1;
            oslot_q <= fslot_q;
            otime_q <= now_q;
            olast_q <= !found_q;
            if (!per_q[fslot_q]) begin
              arm_q[fslot_q] <= 1'b0;
              dl_q[fslot_q] <= TIME_MAX;
            end
            if (found_q) begin
              fslot_q <= best_q;
              done_q[best_q] <= 1'b1;
              idx_q <= '0; found_q <= 1'b0;
              state_q <= ST_SCAN;
            end else begin
              fvalid_q <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = ov_q;
  assign fired_slot_o = oslot_q;
  assign fire_time_o  = otime_q;
  assign last_o       = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRE) |-> fvalid_q) else $error("fire without result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_cmd |-> (state_q == ST_IDLE)) else $error("command taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q && $stable(oslot_q)) else $error("result lost");
endmodule

FILE: rtl/deadline_sorted_timer_queue_top.sv
// Start/stop pass through the front queue and are applied by the back end while it is idle.
// A tick scans all 16 slots once per reported expiry plus one extra pass:
// so k expiries take k+1 passes of the one-slot-per-cycle scanner.
// The front queue (2 entries) keeps accepting, until it is full, while the scanner works.
// Reset (rst_ni low, asynchronous): time 0, all slots disarmed.
// Top level; depends on dstq_pkg, dstq_front and dstq_back.
module deadline_sorted_timer_queue_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     mode_i,
  input  logic [dstq_pkg::SLOT_BITS-1:0] slot_i,
  input  logic [31:0]                    interval_i,
  input  logic                           repeat_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dstq_pkg::SLOT_BITS-1:0] fired_slot_o,
  output logic [63:0]                    fire_time_o,
  output logic                           last_o
);
  import dstq_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  dstq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .slot_i, .interval_i,
    .repeat_req_i, .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  dstq_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .fired_slot_o, .fire_time_o, .last_o
  );
endmodule
